[src/hash_ring_successor_map_top_macros.svh]
// Assertion macros shared by the ring map RTL.
`ifndef HASH_RING_SUCCESSOR_MAP_TOP_MACROS_SVH
`define HASH_RING_SUCCESSOR_MAP_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define HRSM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrsm assertion failed");

// Next-cycle implication, checked outside reset
`define HRSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrsm assertion failed");

`endif

[src/hrsm_pkg.sv]
// Shared constants, codes and types of the hash ring successor map.
package hrsm_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_BITS = 32;
   localparam int ID_BITS  = 16;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Fixed field widths of the request and response channels
   localparam int MODE_W   = 2;
   localparam int REQ_KEY_W = 32;
   localparam int REQ_ID_W  = 16;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 7;

   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd3;

   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [ID_BITS-1:0]  id_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CNT_W-1:0]    cnt_type;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic cmp;
      logic ins;
      logic del;
   } cell_ctl_type;

endpackage

[src/hrsm_cell.sv]
// One ring cell: holds one sorted entry, compares it and shifts with its neighbours.
module hrsm_cell (
   input  logic                  clock,
   input  hrsm_pkg::idx_type     idx,
   input  hrsm_pkg::cnt_type     fill,
   input  hrsm_pkg::cell_ctl_type ctl,
   input  hrsm_pkg::key_type     query_key,
   input  hrsm_pkg::id_type      new_id,
   input  hrsm_pkg::key_type     left_key,
   input  hrsm_pkg::id_type      left_id,
   input  logic                  left_gt,
   input  hrsm_pkg::key_type     right_key,
   input  hrsm_pkg::id_type      right_id,
   output hrsm_pkg::key_type     key,
   output hrsm_pkg::id_type      id,
   output logic                  gt,
   output logic                  ge
);
   import hrsm_pkg::*;

   key_type key_ff, key_in;
   id_type  id_ff, id_in;
   logic    gt_ff, gt_in;
   logic    ge_ff, ge_in;
   logic    occupied;
   logic    at_fill;

   assign occupied = cnt_type'(idx) < fill;
   assign at_fill  = cnt_type'(idx) == fill;

   // Compare against the query, or shift entries for insert and delete
   always_comb begin
      key_in = key_ff;
      id_in  = id_ff;
      gt_in  = gt_ff;
      ge_in  = ge_ff;
      if (ctl.cmp) begin
         gt_in = occupied && (key_ff > query_key);
         ge_in = occupied && (key_ff >= query_key);
      end
      if (ctl.ins) begin
         if (left_gt) begin
            key_in = left_key;
            id_in  = left_id;
         end else if (gt_ff || at_fill) begin
            key_in = query_key;
            id_in  = new_id;
         end
      end
      if (ctl.del && ge_ff) begin
         key_in = right_key;
         id_in  = right_id;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      id_ff  <= id_in;
      gt_ff  <= gt_in;
      ge_ff  <= ge_in;
   end

   assign key = key_ff;
   assign id  = id_ff;
   assign gt  = gt_ff;
   assign ge  = ge_ff;

endmodule

[src/hash_ring_successor_map_top.sv]
// Top level of the hash ring successor map: control, cell row and response register.
//
// Request channel (req_valid/req_ready): mode, key and server_id. Mode 0 looks
// up the owner of the smallest key strictly above the query, wrapping to the
// smallest key; mode 1 inserts an entry after any equal keys; mode 2 deletes
// the first entry whose key matches. Response channel (rsp_valid/rsp_ready):
// owner_id, status and entry_total, one response per request, in order.
// Each request passes through three states: accept, a compare state in which
// every cell compares its key with the query in parallel, and an apply state in
// which the row shifts for insert or delete and the response register is loaded.
// The next request may be accepted while a response still waits to be taken; it
// then holds in its apply state until the response register is free.
// Reset empties the ring (entry count to zero) and clears the handshakes;
// cell contents are left as they are and only counted entries are read.
// A stalled receiver holds the response unchanged until it is taken.
`include "hash_ring_successor_map_top_macros.svh"

module hash_ring_successor_map_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [hrsm_pkg::MODE_W-1:0]       req_mode,
   input  logic [hrsm_pkg::REQ_KEY_W-1:0]    req_key,
   input  logic [hrsm_pkg::REQ_ID_W-1:0]     req_server_id,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [hrsm_pkg::REQ_ID_W-1:0]     rsp_owner_id,
   output logic [hrsm_pkg::STATUS_W-1:0]     rsp_status,
   output logic [hrsm_pkg::TOTAL_W-1:0]      rsp_entry_total
);
   import hrsm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_CMP   = 3'b010,
      ST_APPLY = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   key_type           key_ff, key_in;
   id_type            sid_ff, sid_in;
   cnt_type           fill_ff, fill_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [REQ_ID_W-1:0] owner_ff, owner_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;

   cell_ctl_type ctl;
   key_type cell_key [CAPACITY];
   id_type  cell_id  [CAPACITY];
   logic [CAPACITY-1:0] cell_gt;
   logic [CAPACITY-1:0] cell_ge;

   logic    req_fire;
   logic    apply_go;
   logic    any_gt;
   logic    any_eq;
   id_type  hit_id;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign apply_go  = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ready);

   // Row of cells, each linked to its left and right neighbour
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      key_type lk, rk;
      id_type  lid, rid;
      logic    lgt;
      if (g == 0) begin : g_first
         assign lk  = '0;
         assign lid = '0;
         assign lgt = 1'b0;
      end else begin : g_mid
         assign lk  = cell_key[g-1];
         assign lid = cell_id[g-1];
         assign lgt = cell_gt[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign rk  = '0;
         assign rid = '0;
      end else begin : g_rmid
         assign rk  = cell_key[g+1];
         assign rid = cell_id[g+1];
      end
      hrsm_cell u_cell (
         .clock     (clock),
         .idx       (idx_type'(g)),
         .fill      (fill_ff),
         .ctl       (ctl),
         .query_key (key_ff),
         .new_id    (sid_ff),
         .left_key  (lk),
         .left_id   (lid),
         .left_gt   (lgt),
         .right_key (rk),
         .right_id  (rid),
         .key       (cell_key[g]),
         .id        (cell_id[g]),
         .gt        (cell_gt[g]),
         .ge        (cell_ge[g])
      );
   end

   // Reduce the compare flags and pick the successor owner
   always_comb begin
      logic prev_gt;
      logic sel;
      any_gt  = |cell_gt;
      any_eq  = |(cell_ge & ~cell_gt);
      hit_id  = '0;
      prev_gt = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         sel = cell_gt[i] && !prev_gt;
         if (i == 0 && !any_gt) begin
            sel = 1'b1;
         end
         hit_id  = hit_id | (sel ? cell_id[i] : '0);
         prev_gt = cell_gt[i];
      end
   end

   // Sequence the request and build the response
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      sid_in       = sid_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      owner_in     = owner_ff;
      status_in    = status_ff;
      total_in     = total_ff;
      ctl          = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in  = req_mode;
               key_in   = key_type'(req_key);
               sid_in   = id_type'(req_server_id);
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            ctl.cmp  = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (apply_go) begin
               owner_in  = '0;
               status_in = STAT_OK;
               case (mode_ff)
                  MODE_LOOKUP: begin
                     if (fill_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        owner_in = REQ_ID_W'(hit_id);
                     end
                  end
                  MODE_INSERT: begin
                     if (fill_ff >= cnt_type'(CAPACITY)) begin
                        status_in = STAT_FULL;
                     end else begin
                        ctl.ins = 1'b1;
                        fill_in = fill_ff + cnt_type'(1);
                     end
                  end
                  MODE_DELETE: begin
                     if (any_eq) begin
                        ctl.del = 1'b1;
                        fill_in = fill_ff - cnt_type'(1);
                     end else begin
                        status_in = STAT_MISSING;
                     end
                  end
                  default: begin
                     status_in = STAT_OK;
                  end
               endcase
               total_in     = TOTAL_W'(fill_in);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and response payload
   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      key_ff    <= key_in;
      sid_ff    <= sid_in;
      owner_ff  <= owner_in;
      status_ff <= status_in;
      total_ff  <= total_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_owner_id    = owner_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_total = total_ff;

   `HRSM_ASSERT_NOW(a_fill_bounded, clock, reset, 1'b1, fill_ff <= cnt_type'(CAPACITY))
   `HRSM_ASSERT_NEXT(a_accept_to_cmp, clock, reset, req_fire, state_ff == ST_CMP)
   `HRSM_ASSERT_NOW(a_full_means_full, clock, reset, rsp_valid_ff && status_ff == STAT_FULL, fill_ff == cnt_type'(CAPACITY))
   `HRSM_ASSERT_NEXT(a_apply_loads_rsp, clock, reset, apply_go, rsp_valid_ff && state_ff == ST_IDLE)

endmodule
